### rtl/tps_pkg.sv
// Package with payload types, action codes and constants of the tracker sequencer.
package tps_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [6:0]  index;
    logic [7:0]  order_value;
    logic [7:0]  ins_volume;
    logic [15:0] ins_len_words;
    logic [15:0] ins_loop_words;
    logic        ins_present;
    logic [15:0] note_period;
    logic [15:0] note_cmd;
  } tps_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  channel;
    logic [15:0] frequency;
    logic [7:0]  volume;
    logic [3:0]  sample_slot;
    logic [16:0] length;
    logic [16:0] loop_start;
    logic [16:0] loop_length;
    logic [15:0] mark_value;
    logic [17:0] fetch_offset;
    logic        last;
  } tps_out_t;

  // Instrument table entry: present, volume, length words, loop words.
  typedef struct packed {
    logic        present;
    logic [7:0]  volume;
    logic [15:0] len_words;
    logic [15:0] loop_words;
  } tps_ins_t;

  localparam logic [1:0] FUNC_LOAD_INS = 2'd0;
  localparam logic [1:0] FUNC_LOAD_ORD = 2'd1;
  localparam logic [1:0] FUNC_CELL     = 2'd2;
  localparam logic [1:0] FUNC_START    = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_VOL   = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_PLAY  = 3'd3;
  localparam logic [2:0] ACT_MARK  = 3'd4;
  localparam logic [2:0] ACT_END   = 3'd5;

  localparam logic [15:0] PERIOD_MARK = 16'hFFFD;
  localparam logic [15:0] PERIOD_STOP = 16'hFFFE;
  localparam logic [22:0] PAULA_CLOCK = 23'd7159092;
  localparam logic [11:0] PERIOD_MIN  = 12'h037;
  localparam logic [11:0] PERIOD_MAX  = 12'hFFF;
  localparam logic [7:0]  VOL_MAX     = 8'h3F;

  localparam logic [0:0] CFG_SONG_LENGTH = 1'd0;
  localparam logic [0:0] CFG_START_ORDER = 1'd1;

endpackage

### rtl/tps_divider.sv
// Restoring divider: the Paula clock divided by twice the clamped period.
module tps_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import tps_pkg::*;

  logic [22:0] rem_r, rem_nxt;
  logic [22:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [23:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[22]} - {11'd0, divisor};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = PAULA_CLOCK;
      cnt_nxt  = 5'd23;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[23]) begin
        rem_nxt = trial[22:0];
        quo_nxt = {quo_r[21:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[21:0], quo_r[22]};
        quo_nxt = {quo_r[21:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[15:0];

endmodule

### rtl/tracker_pattern_sequencer_core.sv
// Top level of the four-channel tracker pattern sequencer.
//
// Input transactions on in_* carry one item: an instrument load, an order
// load, a pattern cell or a start. Results leave on out_* one per cycle at
// most, up to three per item; the last one of an item has last set.
// Configuration writes on cfg_* set song_length (index 0) and start_order
// (index 1); they are to be taken only while the block is idle, which the
// block itself does not enforce. Loads and inactive cells finish with no
// result. A start or an active cell reads the order memory and instrument
// memory into registers, then emits its results; a played note first runs
// the 23-step serial divider.
// One item is processed at a time; in_stall is high while one is in work.
// Reset clears the position, the channel counter, the active flag and the
// instrument present bits; order entries are undefined until written.
// While out_stall is high the current result holds in the output register
// and the block waits.
module tracker_pattern_sequencer_core #(
  parameter int ORDER_DEPTH      = 128,
  parameter int INSTRUMENT_SLOTS = 15,
  parameter int CHANNELS         = 4,
  parameter int PATTERN_BYTES    = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tps_pkg::tps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tps_pkg::tps_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import tps_pkg::*;

  localparam int OW  = $clog2(ORDER_DEPTH);
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW  = $clog2(PATTERN_BYTES);
  localparam int SW  = (INSTRUMENT_SLOTS > 1) ? $clog2(INSTRUMENT_SLOTS) : 1;
  localparam int PSH = $clog2(PATTERN_BYTES);
  localparam logic [RW:0] ROW_STEP = (RW+1)'(CHANNELS * 4);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [7:0]     order_mem [ORDER_DEPTH];
  tps_ins_t       ins_mem   [INSTRUMENT_SLOTS];
  logic [INSTRUMENT_SLOTS-1:0] ins_ok_r;
  logic [7:0]     ord_rd_r;
  tps_ins_t       ins_rd_r;
  logic           ins_ok_rd_r;

  logic [7:0]     song_length_r;
  logic [6:0]     start_order_r;
  logic [OW-1:0]  order_pos_r;
  logic [RW-1:0]  row_r;
  logic [CW-1:0]  chan_r;
  logic           active_r;

  logic [2:0]     st_r, st_nxt;
  tps_in_t        item_r;
  logic [CW-1:0]  ch_item_r;
  logic           end_r;
  tps_out_t       res_r [3];
  logic [1:0]     nres_r, idx_r;
  logic           out_valid_r;
  tps_out_t       out_r;
  tps_out_t       out_nxt;

  logic           div_start, div_done;
  logic [15:0]    div_q;
  logic [12:0]    div_den;

  logic           accept;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Cell decode fields on the registered item.
  logic [3:0]  slot_n;
  logic [3:0]  eff;
  logic [7:0]  param;
  logic        has_ins;
  logic [8:0]  vsum;
  logic [7:0]  vol;
  logic [15:0] per;
  logic [11:0] pcl;
  logic [16:0] len_b;
  logic        is_mark, is_stop, is_play;

  always_comb begin
    slot_n  = item_r.note_cmd[15:12];
    eff     = item_r.note_cmd[11:8];
    param   = item_r.note_cmd[7:0];
    per     = item_r.note_period;
    has_ins = (per != PERIOD_MARK) && (slot_n != 4'd0) &&
              ({28'd0, slot_n} <= INSTRUMENT_SLOTS) && ins_ok_rd_r &&
              ins_rd_r.present;
    vol = ins_rd_r.volume;
    vsum = '0;
    if (eff == 4'd5) begin
      vsum = {1'b0, ins_rd_r.volume} + {1'b0, param};
      vol  = (vsum > {1'b0, VOL_MAX}) ? VOL_MAX : vsum[7:0];
    end else if (eff == 4'd6) begin
      vol = (ins_rd_r.volume < param) ? 8'd0 : ins_rd_r.volume - param;
    end
    is_mark = (per == PERIOD_MARK);
    is_stop = (per == PERIOD_STOP);
    is_play = !is_mark && !is_stop && (per != 16'd0) && has_ins;
    if (per < {4'd0, PERIOD_MIN})      pcl = PERIOD_MIN;
    else if (per > {4'd0, PERIOD_MAX}) pcl = PERIOD_MAX;
    else                               pcl = per[11:0];
    len_b = {ins_rd_r.len_words, 1'b0};
  end

  assign div_den   = {pcl, 1'b0};
  assign div_start = (st_r == ST_READ) && item_r.func == FUNC_CELL && is_play;

  tps_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [17:0] fetch;
  assign fetch = 18'(({10'd0, ord_rd_r} << PSH) + {8'd0, row_r} +
                 {{(18-CW-2){1'b0}}, chan_r, 2'b00});

  // Memories. The instrument entry is read once, when the cell is taken, and
  // held for the whole transaction.
  logic [3:0] rd_slot;
  assign rd_slot = in_data.note_cmd[15:12] - 4'd1;
  always_ff @(posedge clk) begin
    if (accept && in_data.func == FUNC_LOAD_ORD &&
        {25'd0, in_data.index} < ORDER_DEPTH)
      order_mem[OW'(in_data.index)] <= in_data.order_value;
    if (accept && in_data.func == FUNC_LOAD_INS &&
        {25'd0, in_data.index} < INSTRUMENT_SLOTS)
      ins_mem[SW'(in_data.index)] <= {in_data.ins_present, in_data.ins_volume,
                                      in_data.ins_len_words, in_data.ins_loop_words};
    if (accept) begin
      if ({28'd0, rd_slot} < INSTRUMENT_SLOTS)
        ins_rd_r <= ins_mem[SW'(rd_slot)];
      ins_ok_rd_r <= ({28'd0, rd_slot} < INSTRUMENT_SLOTS) && ins_ok_r[SW'(rd_slot)];
    end
  end

  // Order memory read of the position after this item.
  logic [OW-1:0] rd_pos;
  always_ff @(posedge clk) ord_rd_r <= order_mem[rd_pos];

  // Position update computed at acceptance.
  logic [OW-1:0] pos_n;
  logic [RW-1:0] row_n;
  logic [CW-1:0] chan_n;
  logic          act_n, end_n;
  logic [RW:0]   row_sum;
  logic [8:0]    nxt_cnt;
  always_comb begin
    pos_n = order_pos_r; row_n = row_r; chan_n = chan_r; act_n = active_r;
    end_n = 1'b0;
    row_sum = {1'b0, row_r} + ROW_STEP;
    nxt_cnt = {{(9-OW){1'b0}}, order_pos_r} + 9'd1;
    if (in_data.func == FUNC_START) begin
      act_n = 1'b1; pos_n = OW'(start_order_r); row_n = '0; chan_n = '0;
    end else if (in_data.func == FUNC_CELL && active_r) begin
      if ({{(32-CW){1'b0}}, chan_r} == CHANNELS - 1) begin
        chan_n = '0;
        if (row_sum >= (RW+1)'(PATTERN_BYTES)) begin
          row_n = '0;
          pos_n = OW'(nxt_cnt);
          if (nxt_cnt == {1'b0, song_length_r}) begin
            end_n = 1'b1; act_n = 1'b0;
          end
        end else begin
          row_n = row_sum[RW-1:0];
        end
      end else begin
        chan_n = chan_r + CW'(1);
      end
    end
  end
  assign rd_pos = (accept) ? pos_n : order_pos_r;

  // Result assembly.
  tps_out_t r_vol, r_act, r_end;
  always_comb begin
    r_vol = '0; r_vol.action = ACT_VOL; r_vol.channel = 2'(ch_item_r);
    r_vol.volume = vol; r_vol.fetch_offset = fetch;
    r_act = '0; r_act.channel = 2'(ch_item_r); r_act.fetch_offset = fetch;
    if (is_mark) begin
      r_act.action = ACT_MARK; r_act.mark_value = item_r.note_cmd;
    end else if (is_stop) begin
      r_act.action = ACT_STOP;
    end else begin
      r_act.action = ACT_PLAY; r_act.frequency = div_q; r_act.volume = vol;
      r_act.sample_slot = slot_n - 4'd1; r_act.length = len_b;
      if (ins_rd_r.loop_words != 16'd0) begin
        r_act.loop_start = len_b;
        r_act.loop_length = {ins_rd_r.loop_words, 1'b0};
      end
    end
    r_end = '0; r_end.action = ACT_END; r_end.channel = 2'(ch_item_r);
    r_end.fetch_offset = fetch;
  end

  logic is_start;
  assign is_start = (item_r.func == FUNC_START);

  // A start reports channel 0; a cell without actions reports its channel.
  tps_out_t r_none;
  always_comb begin
    r_none = '0;
    r_none.channel = is_start ? 2'd0 : 2'(ch_item_r);
    r_none.fetch_offset = fetch;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept && (in_data.func == FUNC_START ||
                   (in_data.func == FUNC_CELL && active_r))) st_nxt = ST_READ;
      ST_READ: st_nxt = div_start ? ST_DIV : ST_EMIT;
      ST_DIV:  if (div_done) st_nxt = ST_EMIT;
      ST_EMIT: if (!out_valid_r || !out_stall)
                 if (idx_r == nres_r) st_nxt = (out_valid_r && out_stall) ?
                   ST_EMIT : ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic [1:0] n_c;
  logic [1:0] nres_c;
  always_comb begin
    n_c = 2'd0;
    if (is_start) nres_c = 2'd1;
    else begin
      if (has_ins) n_c = n_c + 2'd1;
      if (is_mark || is_stop || is_play) n_c = n_c + 2'd1;
      if (end_r) n_c = n_c + 2'd1;
      nres_c = (n_c == 2'd0) ? 2'd1 : n_c;
    end
  end

  always_comb begin
    out_nxt      = res_r[idx_r];
    out_nxt.last = (idx_r + 2'd1 == nres_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; song_length_r <= 8'd1; start_order_r <= '0;
      order_pos_r <= '0; row_r <= '0; chan_r <= '0; active_r <= 1'b0;
      ins_ok_r <= '0; out_valid_r <= 1'b0; idx_r <= '0; nres_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SONG_LENGTH) song_length_r <= cfg_data;
        else start_order_r <= cfg_data[6:0];
      end
      if (accept && in_data.func == FUNC_LOAD_INS &&
          {25'd0, in_data.index} < INSTRUMENT_SLOTS)
        ins_ok_r[SW'(in_data.index)] <= 1'b1;
      if (accept) begin
        order_pos_r <= pos_n; row_r <= row_n; chan_r <= chan_n; active_r <= act_n;
      end
      if (st_r == ST_READ || (st_r == ST_DIV && div_done)) begin
        nres_r <= nres_c; idx_r <= '0;
      end
      if (st_r == ST_EMIT && (!out_valid_r || !out_stall) && idx_r != nres_r) begin
        out_r <= out_nxt;
        out_valid_r <= 1'b1;
        idx_r <= idx_r + 2'd1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Register the accepted item; build the result list once the read data and quotient are ready.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data; ch_item_r <= chan_r; end_r <= end_n;
    end
    if (st_r == ST_READ || (st_r == ST_DIV && div_done)) begin
      if (is_start) begin
        res_r[0] <= r_none;
      end else if (has_ins) begin
        res_r[0] <= r_vol;
        res_r[1] <= (is_mark || is_stop || is_play) ? r_act : r_end;
        res_r[2] <= r_end;
      end else if (is_mark || is_stop || is_play) begin
        res_r[0] <= r_act; res_r[1] <= r_end; res_r[2] <= r_end;
      end else if (end_r) begin
        res_r[0] <= r_end; res_r[1] <= r_end; res_r[2] <= r_end;
      end else begin
        res_r[0] <= r_none;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### tb/tb_tracker_pattern_sequencer_core.sv
// Self-checking testbench of the tracker pattern sequencer core with its own sequencer model.
module tb_tracker_pattern_sequencer_core;
  import tps_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tps_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tps_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  tracker_pattern_sequencer_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  tps_in_t  pending_items[$];
  tps_out_t expected_actions[$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_request = 1'b0;
  int       hold_left = 0;

  // Sequencer state as the testbench sees it.
  tps_ins_t   ins_table[15];
  logic [7:0] order_table[128];
  int         play_pos = 0;
  int         row_ofs = 0;
  int         chan_idx = 0;
  bit         playing = 1'b0;
  int         song_len_reg = 1;
  int         start_ord_reg = 0;

  function automatic void predict_item(input tps_in_t it);
    tps_out_t res[$];
    tps_out_t r;
    tps_ins_t ins;
    bit       ins_ok;
    int       vol, p, slot, eff, param, nxt, ch;
    logic [16:0] len;
    logic [17:0] fo;
    case (it.func)
      FUNC_LOAD_INS: begin
        if (it.index < 15) begin
          ins_table[it.index] = '{present: it.ins_present, volume: it.ins_volume,
                                  len_words: it.ins_len_words, loop_words: it.ins_loop_words};
        end
        return;
      end
      FUNC_LOAD_ORD: begin
        order_table[it.index] = it.order_value;
        return;
      end
      FUNC_START: begin
        playing = 1'b1;
        play_pos = start_ord_reg % 128;
        row_ofs = 0;
        chan_idx = 0;
        r = '0;
        res.push_back(r);
      end
      default: begin
        if (!playing) return;
        ch = chan_idx;
        slot = it.note_cmd[15:12];
        eff = it.note_cmd[11:8];
        param = it.note_cmd[7:0];
        ins = (slot != 0) ? ins_table[slot-1] : '0;
        ins_ok = it.note_period != PERIOD_MARK && slot != 0 && ins.present;
        vol = 0;
        if (ins_ok) begin
          vol = ins.volume;
          if (eff == 5) begin
            vol = vol + param;
            if (vol > VOL_MAX) vol = VOL_MAX;
          end else if (eff == 6) begin
            vol = vol - param;
            if (vol < 0) vol = 0;
          end
          r = '0;
          r.action = ACT_VOL;
          r.channel = 2'(ch);
          r.volume = vol[7:0];
          res.push_back(r);
        end
        if (it.note_period == PERIOD_MARK) begin
          r = '0;
          r.action = ACT_MARK;
          r.channel = 2'(ch);
          r.mark_value = it.note_cmd;
          res.push_back(r);
        end else if (it.note_period == PERIOD_STOP) begin
          r = '0;
          r.action = ACT_STOP;
          r.channel = 2'(ch);
          res.push_back(r);
        end else if (it.note_period != 0 && ins_ok) begin
          p = it.note_period;
          if (p < PERIOD_MIN) p = PERIOD_MIN;
          if (p > PERIOD_MAX) p = PERIOD_MAX;
          len = {ins.len_words, 1'b0};
          r = '0;
          r.action = ACT_PLAY;
          r.channel = 2'(ch);
          r.frequency = 16'(PAULA_CLOCK / (p * 2));
          r.volume = vol[7:0];
          r.sample_slot = 4'(slot - 1);
          r.length = len;
          if (ins.loop_words != 0) begin
            r.loop_start = len;
            r.loop_length = {ins.loop_words, 1'b0};
          end
          res.push_back(r);
        end
        chan_idx++;
        if (chan_idx >= 4) begin
          chan_idx = 0;
          row_ofs += 16;
          if (row_ofs >= 1024) begin
            nxt = play_pos + 1;
            row_ofs = 0;
            if (nxt == song_len_reg) begin
              r = '0;
              r.action = ACT_END;
              r.channel = 2'(ch);
              res.push_back(r);
              playing = 1'b0;
            end
            play_pos = nxt % 128;
          end
        end
        if (res.size() == 0) begin
          r = '0;
          r.channel = 2'(ch);
          res.push_back(r);
        end
      end
    endcase
    fo = 18'(order_table[play_pos] * 1024 + row_ofs + chan_idx * 4);
    foreach (res[k]) begin
      res[k].fetch_offset = fo;
      res[k].last = (k == res.size() - 1);
      expected_actions.push_back(res[k]);
    end
  endfunction

  // Sender: a transaction is held until accepted; idling is decided only between items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_item(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver with random stalls and an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = 300;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tps_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_actions.size() == 0) begin
        $error("unexpected result transaction: action %0d", out_data.action);
        fail_count++;
      end else begin
        e = expected_actions.pop_front();
        check_field("action", e.action, out_data.action);
        check_field("channel", e.channel, out_data.channel);
        check_field("frequency", e.frequency, out_data.frequency);
        check_field("volume", e.volume, out_data.volume);
        check_field("sample_slot", e.sample_slot, out_data.sample_slot);
        check_field("length", e.length, out_data.length);
        check_field("loop_start", e.loop_start, out_data.loop_start);
        check_field("loop_length", e.loop_length, out_data.loop_length);
        check_field("mark_value", e.mark_value, out_data.mark_value);
        check_field("fetch_offset", e.fetch_offset, out_data.fetch_offset);
        check_field("last", e.last, out_data.last);
      end
    end
  end

  function automatic tps_in_t rand_fields();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(tps_in_t)-1:0];
  endfunction

  function automatic tps_in_t rand_cell();
    tps_in_t it;
    it = rand_fields();
    it.func = FUNC_CELL;
    case ($urandom_range(9))
      0: it.note_period = 16'h0000;
      1: it.note_period = PERIOD_STOP;
      2: it.note_period = PERIOD_MARK;
      3: it.note_period = 16'($urandom_range(16'h36, 1));
      4, 5, 6: it.note_period = 16'($urandom_range(16'hFFF, 16'h37));
      default: ;
    endcase
    if ($urandom_range(2) == 0) it.note_cmd[11:8] = $urandom_range(1) ? 4'd5 : 4'd6;
    return it;
  endfunction

  function automatic tps_in_t rand_item();
    tps_in_t it;
    int pick;
    pick = $urandom_range(99);
    it = rand_fields();
    if (pick < 85) begin
      it = rand_cell();
    end else if (pick < 92) begin
      it.func = FUNC_LOAD_INS;
      if ($urandom_range(3) != 0) it.index = 7'($urandom_range(14));
      if ($urandom_range(3) != 0) it.ins_present = 1'b1;
    end else if (pick < 97) begin
      it.func = FUNC_LOAD_ORD;
    end else begin
      it.func = FUNC_START;
    end
    return it;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_actions.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SONG_LENGTH) song_len_reg = val;
    else start_ord_reg = val[6:0];
  endtask

  task automatic run_phase(input int song_len, input int start_ord, input int s_idle,
                           input int r_stall, input int n_items, input bit long_hold);
    tps_in_t it;
    write_reg(CFG_SONG_LENGTH, 8'(song_len));
    write_reg(CFG_START_ORDER, 8'(start_ord));
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    it = rand_fields();
    it.func = FUNC_START;
    pending_items.push_back(it);
    repeat (n_items) pending_items.push_back(rand_item());
    if (long_hold) begin
      repeat (2) @(posedge clk);
      hold_request = 1'b1;
    end
    wait_idle();
  endtask

  initial begin
    tps_in_t it;
    foreach (ins_table[k]) ins_table[k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Every order entry gets written before any item uses it.
    for (int k = 0; k < 128; k++) begin
      it = rand_fields();
      it.func = FUNC_LOAD_ORD;
      it.index = 7'(k);
      pending_items.push_back(it);
    end

    // Directed items on the reset configuration.
    it = rand_cell();
    pending_items.push_back(it);
    it = '0;
    it.func = FUNC_LOAD_INS;
    it.index = 7'd0; it.ins_volume = 8'hFF; it.ins_len_words = 16'hFFFF;
    it.ins_loop_words = 16'hFFFF; it.ins_present = 1'b1;
    pending_items.push_back(it);
    it.index = 7'd14; it.ins_volume = 8'h00; it.ins_len_words = 16'h0000;
    it.ins_loop_words = 16'h0000;
    pending_items.push_back(it);
    it.index = 7'd1; it.ins_volume = 8'h20; it.ins_present = 1'b0;
    pending_items.push_back(it);
    it.index = 7'd127; it.ins_present = 1'b1;
    pending_items.push_back(it);
    it = '0;
    it.func = FUNC_START;
    pending_items.push_back(it);
    it.func = FUNC_CELL;
    pending_items.push_back(it);
    it.note_period = PERIOD_STOP; it.note_cmd = 16'h1000;
    pending_items.push_back(it);
    it.note_period = PERIOD_MARK; it.note_cmd = 16'hFFFF;
    pending_items.push_back(it);
    it.note_period = 16'h0001; it.note_cmd = 16'h15FF;
    pending_items.push_back(it);
    it.note_period = 16'hFFFF; it.note_cmd = 16'hF6FF;
    pending_items.push_back(it);
    it.note_period = 16'h0200; it.note_cmd = 16'h1610;
    pending_items.push_back(it);
    it.note_period = 16'h0200; it.note_cmd = 16'h2500;
    pending_items.push_back(it);
    it.note_period = 16'h0037; it.note_cmd = 16'hF510;
    pending_items.push_back(it);
    it.note_period = 16'h0FFF; it.note_cmd = 16'h1300;
    pending_items.push_back(it);
    repeat (10) pending_items.push_back(rand_cell());
    wait_idle();

    run_phase(128, 127, 51, 0, 12, 1'b0);
    run_phase(0, 5, 0, 51, 12, 1'b1);
    run_phase(200, 127, 38, 38, 12, 1'b0);
    run_phase(2, 1, 0, 0, 12, 1'b0);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/tps_pkg.sv
rtl/tps_divider.sv
rtl/tracker_pattern_sequencer_core.sv
tb/tb_tracker_pattern_sequencer_core.sv
